@@ design/ckls_pkg.sv @@
`timescale 1ns / 1ps

package ckls_pkg;

    localparam int NUM_TABLES  = 8;
    localparam int MAX_RECORDS = 256;

    localparam int TAB_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int SLOT_W    = $clog2(MAX_RECORDS);
    localparam int CNT_W     = $clog2(MAX_RECORDS + 1);
    localparam int MEM_DEPTH = NUM_TABLES * MAX_RECORDS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int VALUE_W   = 16;
    localparam int CASTE_W   = 8;
    localparam int REC_W     = VALUE_W + CASTE_W;
    localparam int OUT_SLOT_W = 8;

    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_COUNT  = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_COUNT,
        OP_SEARCH,
        OP_MISS
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [TAB_W-1:0]          tab;
        logic [SLOT_W-1:0]         slot;
        logic [CNT_W-1:0]          count;
        logic signed [VALUE_W-1:0] value;
        logic [CASTE_W-1:0]        caste;
    } entry_t;

endpackage

@@ design/ckls_front.sv @@
`timescale 1ns / 1ps

module ckls_front (
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [1:0]            cmd,
    input  logic [2:0]            index_select,
    input  logic [7:0]            position,
    input  logic signed [15:0]    key_value,
    input  logic [7:0]            key_caste,
    input  logic [8:0]            record_count,
    output logic                  push_valid,
    input  logic                  push_ready,
    output ckls_pkg::entry_t      push_data
);
    import ckls_pkg::*;

    logic tab_ok;
    logic pos_ok;
    logic keep;

    assign tab_ok     = int'(index_select) < NUM_TABLES;
    assign pos_ok     = int'(position) < MAX_RECORDS;
    assign item_ready = push_ready;
    assign push_valid = item_valid && keep;

    always_comb
    begin
        push_data.op    = OP_MISS;
        push_data.tab   = TAB_W'(index_select);
        push_data.slot  = SLOT_W'(position);
        push_data.value = VALUE_W'(key_value);
        push_data.caste = CASTE_W'(key_caste);
        if (int'(record_count) > MAX_RECORDS)
        begin
            push_data.count = CNT_W'(MAX_RECORDS);
        end
        else
        begin
            push_data.count = CNT_W'(record_count);
        end
        keep = 1'b0;
        case (cmd)
            CMD_WRITE:
            begin
                push_data.op = OP_WRITE;
                keep         = tab_ok && pos_ok;
            end
            CMD_COUNT:
            begin
                push_data.op = OP_COUNT;
                keep         = tab_ok;
            end
            CMD_SEARCH:
            begin
                push_data.op = tab_ok ? OP_SEARCH : OP_MISS;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

@@ design/ckls_fifo.sv @@
`timescale 1ns / 1ps

module ckls_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ckls_pkg::entry_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ckls_pkg::entry_t pop_data
);
    import ckls_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    entry_t              slots_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [FCNT_W-1:0]   count_reg;
    logic [FCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != FCNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("queue fill count exceeds its depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count missed a push");

endmodule

@@ design/ckls_back.sv @@
`timescale 1ns / 1ps

module ckls_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  ckls_pkg::entry_t    pop_data,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                found,
    output logic [7:0]          match_slot
);
    import ckls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_RESULT
    } state_t;

    function automatic logic [ADDR_W-1:0] rec_addr(input logic [TAB_W-1:0] tab,
                                                   input logic [SLOT_W-1:0] slot);
        rec_addr = ADDR_W'(tab) * ADDR_W'(MAX_RECORDS) + ADDR_W'(slot);
    endfunction

    logic [REC_W-1:0]          mem [MEM_DEPTH];
    logic [REC_W-1:0]          rdata_reg;
    logic [CNT_W-1:0]          counts_reg [NUM_TABLES];

    state_t                    state_reg;
    state_t                    state_next;
    logic [TAB_W-1:0]          tab_reg;
    logic [TAB_W-1:0]          tab_next;
    logic signed [VALUE_W-1:0] key_value_reg;
    logic signed [VALUE_W-1:0] key_value_next;
    logic [CASTE_W-1:0]        key_caste_reg;
    logic [CASTE_W-1:0]        key_caste_next;
    logic [CNT_W-1:0]          n_reg;
    logic [CNT_W-1:0]          n_next;
    logic [CNT_W-1:0]          lo_reg;
    logic [CNT_W-1:0]          lo_next;
    logic [CNT_W-1:0]          hi_reg;
    logic [CNT_W-1:0]          hi_next;
    logic [SLOT_W-1:0]         mid_reg;
    logic [SLOT_W-1:0]         mid_next;
    logic                      pfound_reg;
    logic                      pfound_next;
    logic [OUT_SLOT_W-1:0]     pslot_reg;
    logic [OUT_SLOT_W-1:0]     pslot_next;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    logic                      found_reg;
    logic                      found_next;
    logic [OUT_SLOT_W-1:0]     slot_reg;
    logic [OUT_SLOT_W-1:0]     slot_next;

    logic                      mem_we;
    logic [ADDR_W-1:0]         wr_addr;
    logic [REC_W-1:0]          wr_data;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      cnt_we;
    logic [CNT_W-1:0]          n_sel;
    logic [CNT_W-1:0]          lo_t;
    logic [CNT_W-1:0]          hi_t;
    logic [CNT_W:0]            sum_t;
    logic [SLOT_W-1:0]         mid_t;
    logic signed [VALUE_W-1:0] rec_value;
    logic [CASTE_W-1:0]        rec_caste;
    logic                      not_less;
    logic                      exact;
    logic                      out_free;

    assign rec_value    = $signed(rdata_reg[VALUE_W-1:0]);
    assign rec_caste    = rdata_reg[REC_W-1:VALUE_W];
    assign not_less     = (rec_caste != key_caste_reg) ? (rec_caste > key_caste_reg)
                                                       : (rec_value >= key_value_reg);
    assign exact        = (rec_caste == key_caste_reg) && (rec_value == key_value_reg);
    assign out_free     = !result_valid_reg || result_ready;
    assign n_sel        = counts_reg[pop_data.tab];
    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign match_slot   = slot_reg;
    assign cnt_we       = (state_reg == S_IDLE) && pop_valid && (pop_data.op == OP_COUNT);

    always_comb
    begin
        state_next        = state_reg;
        tab_next          = tab_reg;
        key_value_next    = key_value_reg;
        key_caste_next    = key_caste_reg;
        n_next            = n_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        pfound_next       = pfound_reg;
        pslot_next        = pslot_reg;
        result_valid_next = result_valid_reg && !result_ready;
        found_next        = found_reg;
        slot_next         = slot_reg;
        pop_ready         = 1'b0;
        mem_we            = 1'b0;
        wr_addr           = rec_addr(pop_data.tab, pop_data.slot);
        wr_data           = {pop_data.caste, pop_data.value};
        rd_addr           = '0;
        lo_t              = lo_reg;
        hi_t              = hi_reg;
        sum_t             = '0;
        mid_t             = '0;

        case (state_reg)
            S_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    case (pop_data.op)
                        OP_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        OP_SEARCH:
                        begin
                            tab_next       = pop_data.tab;
                            key_value_next = pop_data.value;
                            key_caste_next = pop_data.caste;
                            n_next         = n_sel;
                            lo_next        = '0;
                            hi_next        = n_sel;
                            mid_t          = SLOT_W'(n_sel >> 1);
                            mid_next       = mid_t;
                            rd_addr        = rec_addr(pop_data.tab, mid_t);
                            if (n_sel == '0)
                            begin
                                pfound_next = 1'b0;
                                pslot_next  = '0;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                        OP_MISS:
                        begin
                            pfound_next = 1'b0;
                            pslot_next  = '0;
                            state_next  = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (not_less)
                begin
                    hi_t = CNT_W'(mid_reg);
                end
                else
                begin
                    lo_t = CNT_W'(mid_reg) + 1'b1;
                end
                sum_t   = {1'b0, lo_t} + {1'b0, hi_t};
                mid_t   = SLOT_W'(sum_t >> 1);
                lo_next = lo_t;
                hi_next = hi_t;
                if (lo_t < hi_t)
                begin
                    mid_next = mid_t;
                    rd_addr  = rec_addr(tab_reg, mid_t);
                end
                else if (lo_t < n_reg)
                begin
                    rd_addr    = rec_addr(tab_reg, SLOT_W'(lo_t));
                    state_next = S_CHECK;
                end
                else
                begin
                    pfound_next = 1'b0;
                    pslot_next  = '0;
                    state_next  = S_RESULT;
                end
            end
            S_CHECK:
            begin
                pfound_next = exact;
                pslot_next  = exact ? OUT_SLOT_W'(lo_reg) : '0;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    found_next        = pfound_reg;
                    slot_next         = pslot_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cnt_we)
            begin
                counts_reg[pop_data.tab] <= pop_data.count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tab_reg       <= tab_next;
        key_value_reg <= key_value_next;
        key_caste_reg <= key_caste_next;
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pfound_reg    <= pfound_next;
        pslot_reg     <= pslot_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg < hi_reg) && (hi_reg <= n_reg))
        else $error("search window is empty or beyond the record count");

    a_probe_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (CNT_W'(mid_reg) >= lo_reg) && (CNT_W'(mid_reg) < hi_reg))
        else $error("probe position lies outside the search window");

    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop_ready)
        else $error("queue popped while a search is in progress");

    a_found_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !found_reg) |-> (slot_reg == '0))
        else $error("result without a match carries a nonzero slot");

endmodule

@@ design/compound_key_lower_bound_search.sv @@
`timescale 1ns / 1ps

// Holds eight sorted tables of up to 256 records, each a signed 16-bit value and an 8-bit class,
// ordered by class and then by value; the tables are assumed sorted and this is not checked.
// A write or count transaction is classified at the input and queued, and the back end retires it
// without leaving its idle state; one that names an out-of-range table is dropped at the input. A
// search runs a lower-bound binary search through the record memory (one write port, one read
// port), one probe per cycle, then, if the lower bound lies within the table, reads that slot to
// check for an exact match. Only searches return a transaction. Searches of an empty or
// out-of-range table return found 0 and slot 0. Records that were never written read as
// undefined.
module compound_key_lower_bound_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         cmd,
    input  logic [2:0]         index_select,
    input  logic [7:0]         position,
    input  logic signed [15:0] key_value,
    input  logic [7:0]         key_caste,
    input  logic [8:0]         record_count,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               found,
    output logic [7:0]         match_slot
);
    import ckls_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_data;

    ckls_front u_front (
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .index_select (index_select),
        .position     (position),
        .key_value    (key_value),
        .key_caste    (key_caste),
        .record_count (record_count),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    ckls_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ckls_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .match_slot   (match_slot)
    );

endmodule
